@@ rtl/core/plist_pkg.sv @@
// Shared constants, codes and command/status types for the positional list engine.
`default_nettype none

package plist_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 3;
  localparam int ST_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT     = 3'd0,
    FN_ERASE      = 3'd1,
    FN_FIND       = 3'd2,
    FN_MODIFY     = 3'd3,
    FN_PUSH_BACK  = 3'd4,
    FN_PUSH_FRONT = 3'd5,
    FN_POP_BACK   = 3'd6,
    FN_POP_FRONT  = 3'd7
  } plist_func_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } plist_status_e;

  typedef enum logic [1:0] {
    IDX_COUNT = 2'd0,
    IDX_POS1  = 2'd1,
    IDX_ZERO  = 2'd2
  } plist_idx_e;

  typedef enum logic [1:0] {
    WR_VAL  = 2'd0,
    WR_UP   = 2'd1,
    WR_DOWN = 2'd2
  } plist_wr_e;

  typedef struct packed {
    logic          load;
    logic          idx_ld;
    plist_idx_e    idx_sel;
    logic          idx_inc;
    logic          idx_dec;
    logic          rd_en;
    logic          rd_up;
    logic          wr_en;
    plist_wr_e     wr_sel;
    logic          cnt_inc;
    logic          cnt_dec;
    logic          res_en;
    plist_status_e res_status;
    logic          res_found;
  } plist_cmd_t;

  typedef struct packed {
    plist_func_e func;
    logic        ins_bad;
    logic        full;
    logic        pos_ge;
    logic        empty;
    logic        up_more;
    logic        down_more;
    logic        match;
  } plist_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/plist_dp.sv @@
// Datapath: entry memory, count, walk index, operand and result registers.
`default_nettype none

module plist_dp import plist_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire plist_cmd_t          cmd_i,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic [VAL_W-1:0]    value_i,
  output plist_stat_t              stat_o,
  output logic [ST_W-1:0]          status_o,
  output logic [POS_W-1:0]         found_position_o,
  output logic [POS_W-1:0]         count_o
);

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rdata_q;
  logic [VAL_W-1:0]  val_q;
  plist_func_e       func_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  idx_q, idx_d;
  logic [POS_W-1:0]  cnt_q, cnt_d;
  logic [ST_W-1:0]   status_q;
  logic [POS_W-1:0]  found_q;
  logic [POS_W-1:0]  idx_m1;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;

  assign idx_m1 = idx_q - POS_W'(1);

  always_comb begin
    unique case (plist_func_e'(func_i))
      FN_PUSH_BACK:                pos_d = cnt_q;
      FN_PUSH_FRONT, FN_POP_FRONT: pos_d = '0;
      default:                     pos_d = position_i;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_ld) begin
      unique case (cmd_i.idx_sel)
        IDX_COUNT: idx_d = cnt_q;
        IDX_POS1:  idx_d = pos_q + POS_W'(1);
        default:   idx_d = '0;
      endcase
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + POS_W'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_m1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + POS_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - POS_W'(1);
    end
  end

  assign rd_addr = cmd_i.rd_up ? idx_m1[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_UP: begin
        wr_addr = idx_q[ADDR_W-1:0];
        wr_data = rdata_q;
      end
      WR_DOWN: begin
        wr_addr = idx_m1[ADDR_W-1:0];
        wr_data = rdata_q;
      end
      default: begin
        wr_addr = pos_q[ADDR_W-1:0];
        wr_data = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (cmd_i.load) begin
      val_q  <= value_i;
      func_q <= plist_func_e'(func_i);
      pos_q  <= pos_d;
    end
    if (cmd_i.res_en) begin
      status_q <= cmd_i.res_status;
      found_q  <= cmd_i.res_found ? (idx_q + POS_W'(1)) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  assign stat_o.func      = func_q;
  assign stat_o.ins_bad   = pos_q > cnt_q;
  assign stat_o.full      = cnt_q >= POS_W'(DEPTH);
  assign stat_o.pos_ge    = pos_q >= cnt_q;
  assign stat_o.empty     = cnt_q == '0;
  assign stat_o.up_more   = idx_q > pos_q;
  assign stat_o.down_more = idx_q < cnt_q;
  assign stat_o.match     = rdata_q == val_q;

  assign status_o         = status_q;
  assign found_position_o = found_q;
  assign count_o          = cnt_q;

endmodule

`default_nettype wire

@@ rtl/core/plist_ctrl.sv @@
// Controller: command decode and sequencing of shift and search walks.
`default_nettype none

module plist_ctrl import plist_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire plist_stat_t stat_i,
  output plist_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_FND_RD,
    S_FND_CMP
  } state_e;

  state_e state_q, state_d;
  logic   resp_q, resp_d;

  always_comb begin
    cmd_o            = '0;
    cmd_o.idx_sel    = IDX_ZERO;
    cmd_o.wr_sel     = WR_VAL;
    cmd_o.res_status = ST_OK;
    state_d          = state_q;
    resp_d           = resp_q;

    if (resp_q) begin
      if (out_ready_i) begin
        resp_d = 1'b0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = S_DECODE;
          end
        end
        S_DECODE: begin
          cmd_o.res_en = 1'b1;
          state_d      = S_IDLE;
          resp_d       = 1'b1;
          unique case (stat_i.func)
            FN_INSERT, FN_PUSH_BACK, FN_PUSH_FRONT: begin
              if (stat_i.ins_bad) begin
                cmd_o.res_status = ST_BADPOS;
              end else if (stat_i.full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.res_en  = 1'b0;
                cmd_o.idx_ld  = 1'b1;
                cmd_o.idx_sel = IDX_COUNT;
                state_d       = S_UP_RD;
                resp_d        = 1'b0;
              end
            end
            FN_ERASE, FN_POP_FRONT: begin
              if (stat_i.empty && stat_i.func == FN_POP_FRONT) begin
                cmd_o.res_status = ST_EMPTY;
              end else if (stat_i.pos_ge) begin
                cmd_o.res_status = ST_BADPOS;
              end else begin
                cmd_o.res_en  = 1'b0;
                cmd_o.idx_ld  = 1'b1;
                cmd_o.idx_sel = IDX_POS1;
                state_d       = S_DN_RD;
                resp_d        = 1'b0;
              end
            end
            FN_POP_BACK: begin
              if (stat_i.empty) begin
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.cnt_dec = 1'b1;
              end
            end
            FN_MODIFY: begin
              if (stat_i.pos_ge) begin
                cmd_o.res_status = ST_BADPOS;
              end else begin
                cmd_o.wr_en = 1'b1;
              end
            end
            default: begin
              cmd_o.res_en  = 1'b0;
              cmd_o.idx_ld  = 1'b1;
              cmd_o.idx_sel = IDX_ZERO;
              state_d       = S_FND_RD;
              resp_d        = 1'b0;
            end
          endcase
        end
        S_UP_RD: begin
          if (stat_i.up_more) begin
            cmd_o.rd_en = 1'b1;
            cmd_o.rd_up = 1'b1;
            state_d     = S_UP_WR;
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.cnt_inc = 1'b1;
            cmd_o.res_en  = 1'b1;
            state_d       = S_IDLE;
            resp_d        = 1'b1;
          end
        end
        S_UP_WR: begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WR_UP;
          cmd_o.idx_dec = 1'b1;
          state_d       = S_UP_RD;
        end
        S_DN_RD: begin
          if (stat_i.down_more) begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_DN_WR;
          end else begin
            cmd_o.cnt_dec = 1'b1;
            cmd_o.res_en  = 1'b1;
            state_d       = S_IDLE;
            resp_d        = 1'b1;
          end
        end
        S_DN_WR: begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WR_DOWN;
          cmd_o.idx_inc = 1'b1;
          state_d       = S_DN_RD;
        end
        S_FND_RD: begin
          if (stat_i.down_more) begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_FND_CMP;
          end else begin
            cmd_o.res_en     = 1'b1;
            cmd_o.res_status = ST_NOTFOUND;
            state_d          = S_IDLE;
            resp_d           = 1'b1;
          end
        end
        S_FND_CMP: begin
          if (stat_i.match) begin
            cmd_o.res_en    = 1'b1;
            cmd_o.res_found = 1'b1;
            state_d         = S_IDLE;
            resp_d          = 1'b1;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_FND_RD;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !resp_q;
  assign out_valid_o = resp_q;

endmodule

`default_nettype wire

@@ rtl/core/positional_list_engine.sv @@
// Top level of the positional list engine: ordered list of signed words with count.
//
//  channel  | dir | tuser          | tdata (low bit up)
//  s_axis   | in  | func [2:0]     | position [6:0], value [38:7], zero [39]
//  m_axis   | out | status [2:0]   | found_position [6:0], count [13:7], zero [15:14]
//
//  One item at a time; the result is held until taken, then the next item is accepted.
//  Modify, pop_back and rejected items finish in decode; insert, push, erase and pop_front
//  walk the entries to be moved, and find walks the entries until a match or the end.
//  Walks use the single-port entry memory with registered read.
//  Reset clears the count and control; entry contents are not cleared.
//  A stalled result blocks intake.
`default_nettype none

module positional_list_engine import plist_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // position[6:0], value[38:7], pad
  input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // found_position[6:0], count[13:7], pad
  output logic [2:0]       m_axis_tuser    // status[2:0]
);

  plist_cmd_t       cmd;
  plist_stat_t      stat;
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] found_position;
  logic [POS_W-1:0] count;

  plist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  plist_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .func_i           (s_axis_tuser),
    .position_i       (s_axis_tdata[POS_W-1:0]),
    .value_i          (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
    .stat_o           (stat),
    .status_o         (status),
    .found_position_o (found_position),
    .count_o          (count)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {2'b00, count, found_position};

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the positional list engine: stream commands in, compare results.
`timescale 1ns / 1ps

module tb;
  import plist_pkg::*;

  typedef struct packed {
    plist_func_e       func;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } list_cmd_t;

  typedef struct packed {
    plist_status_e     status;
    logic [POS_W-1:0]  found;
    logic [POS_W-1:0]  count;
  } list_rsp_t;

  typedef enum int {GEN_FILL, GEN_DRAIN, GEN_MIX} gen_mode_e;

  localparam int RANDOM_CMDS = 1800;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 2 * DEPTH + 20;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // position[6:0], value[38:7], pad
  logic [2:0]  s_axis_tuser = '0;   // func[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // found_position[6:0], count[13:7], pad
  logic [2:0]  m_axis_tuser;        // status[2:0]

  positional_list_engine u_top (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  list_cmd_t        cmd_q[$];
  list_rsp_t        rsp_q[$];
  int               cmd_total = 1;
  int               in_cnt = 0;
  int               err_cnt = 0;
  logic             in_fired = 1'b0;
  int               hold_left = 0;
  logic             hold_done = 1'b0;

  // predicted list contents
  logic [VAL_W-1:0] list_vals [DEPTH];
  int               list_len = 0;

  // generator view of the count, to aim positions
  int               gen_len = 0;
  logic [VAL_W-1:0] val_pool [16];

  function automatic int stage_of(int n);
    return (n * 3) / cmd_total;
  endfunction

  function automatic plist_status_e list_insert(int pos, logic [VAL_W-1:0] v);
    int i;
    if (pos > list_len) return ST_BADPOS;
    if (list_len >= DEPTH) return ST_FULL;
    for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
    list_vals[pos] = v;
    list_len++;
    return ST_OK;
  endfunction

  function automatic plist_status_e list_erase(int pos);
    int i;
    if (pos >= list_len) return ST_BADPOS;
    for (i = pos + 1; i < list_len; i++) list_vals[i-1] = list_vals[i];
    list_len--;
    return ST_OK;
  endfunction

  function automatic list_rsp_t list_apply(list_cmd_t c);
    list_rsp_t r;
    int        i;
    r.status = ST_OK;
    r.found  = '0;
    case (c.func)
      FN_INSERT:     r.status = list_insert(int'(c.pos), c.value);
      FN_ERASE:      r.status = list_erase(int'(c.pos));
      FN_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_vals[i] == c.value) begin
            r.found  = POS_W'(i + 1);
            r.status = ST_OK;
            break;
          end
        end
      end
      FN_MODIFY: begin
        if (int'(c.pos) >= list_len) r.status = ST_BADPOS;
        else list_vals[c.pos] = c.value;
      end
      FN_PUSH_BACK:  r.status = list_insert(list_len, c.value);
      FN_PUSH_FRONT: r.status = list_insert(0, c.value);
      FN_POP_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      default: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.status = list_erase(0);
      end
    endcase
    r.count = POS_W'(list_len);
    return r;
  endfunction

  task automatic add_cmd(plist_func_e f, int pos, logic [VAL_W-1:0] v);
    list_cmd_t c;
    c.func  = f;
    c.pos   = POS_W'(pos);
    c.value = v;
    cmd_q.push_back(c);
    case (f)
      FN_INSERT:     if (pos <= gen_len && gen_len < DEPTH) gen_len++;
      FN_PUSH_BACK,
      FN_PUSH_FRONT: if (gen_len < DEPTH) gen_len++;
      FN_ERASE:      if (pos < gen_len) gen_len--;
      FN_POP_BACK,
      FN_POP_FRONT:  if (gen_len > 0) gen_len--;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // sender
  always @(negedge clk) begin : drv
    logic      load;
    list_cmd_t c;
    int        pct;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fired) begin
      case (stage_of(in_cnt))
        0:       pct = 12;
        1:       pct = 65;
        default: pct = 0;
      endcase
      load = (cmd_q.size() != 0) && ($urandom_range(99, 0) >= pct);
      if (load) begin
        c = cmd_q.pop_front();
        s_axis_tuser <= c.func;
        s_axis_tdata <= {1'b0, c.value, c.pos};
      end
      s_axis_tvalid <= load;
    end
  end

  // receiver, with one long hold-off midway
  always @(negedge clk) begin : rcv
    int pct;
    case (stage_of(in_cnt))
      0:       pct = 65;
      1:       pct = 12;
      default: pct = 0;
    endcase
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && in_cnt >= cmd_total / 2) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin : mon
    list_cmd_t     c;
    list_rsp_t     exp_rsp;
    plist_status_e got_st;
    logic [6:0]    got_found;
    logic [6:0]    got_cnt;
    if (!rst_ni) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got_st    = plist_status_e'(m_axis_tuser);
        got_found = m_axis_tdata[6:0];
        got_cnt   = m_axis_tdata[13:7];
        if (rsp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d found=%0d count=%0d",
                                    got_st, got_found, got_cnt));
        end else begin
          exp_rsp = rsp_q.pop_front();
          if (got_st !== exp_rsp.status)
            report_mismatch($sformatf("status exp %0d got %0d", exp_rsp.status, got_st));
          if (got_found !== exp_rsp.found)
            report_mismatch($sformatf("found_position exp %0d got %0d",
                                      exp_rsp.found, got_found));
          if (got_cnt !== exp_rsp.count)
            report_mismatch($sformatf("count exp %0d got %0d", exp_rsp.count, got_cnt));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        c.func  = plist_func_e'(s_axis_tuser);
        c.pos   = s_axis_tdata[6:0];
        c.value = s_axis_tdata[38:7];
        rsp_q.push_back(list_apply(c));
        in_cnt <= in_cnt + 1;
      end
    end
  end

  initial begin : gen
    gen_mode_e        mode;
    int               n;
    int               k;
    int               seg;
    int               r;
    int               pos;
    logic             grow;
    plist_func_e      f;
    logic [VAL_W-1:0] v;

    val_pool[0] = 32'h8000_0000;
    val_pool[1] = 32'h7fff_ffff;
    val_pool[2] = 32'h0000_0000;
    val_pool[3] = 32'hffff_ffff;
    for (k = 4; k < 16; k++) val_pool[k] = $urandom;

    // empty-list corner cases
    add_cmd(FN_POP_BACK,   0,  32'h0);
    add_cmd(FN_POP_FRONT,  0,  32'h0);
    add_cmd(FN_ERASE,      0,  32'h0);
    add_cmd(FN_MODIFY,     0,  32'h1234_5678);
    add_cmd(FN_FIND,       0,  32'h0);
    add_cmd(FN_INSERT,     1,  32'h1);
    // build a short list with extreme values and a duplicate, then find, modify and erase in it, also out of range
    add_cmd(FN_INSERT,     0,  32'h8000_0000);
    add_cmd(FN_PUSH_BACK,  0,  32'h7fff_ffff);
    add_cmd(FN_PUSH_FRONT, 0,  32'hffff_ffff);
    add_cmd(FN_INSERT,     3,  32'h0000_0000);
    add_cmd(FN_INSERT,     2,  32'h7fff_ffff);
    add_cmd(FN_FIND,       0,  32'h7fff_ffff);
    add_cmd(FN_MODIFY,     4,  32'h5555_5555);
    add_cmd(FN_MODIFY,     5,  32'haaaa_aaaa);
    add_cmd(FN_ERASE,      1,  32'h0);
    add_cmd(FN_ERASE,      4,  32'h0);
    add_cmd(FN_FIND,       0,  32'h2aaa_aaaa);
    add_cmd(FN_INSERT,     64, 32'haaaa_aaaa);
    add_cmd(FN_ERASE,      64, 32'h0);
    add_cmd(FN_MODIFY,     64, 32'h0);
    add_cmd(FN_FIND,       0,  32'h5555_5555);
    add_cmd(FN_POP_BACK,   0,  32'h0);
    add_cmd(FN_POP_FRONT,  0,  32'h0);

    // random segments that fill, drain or churn the list
    n = 0;
    while (n < RANDOM_CMDS) begin
      mode = gen_mode_e'($urandom_range(2, 0));
      seg  = $urandom_range(160, 40);
      for (k = 0; k < seg && n < RANDOM_CMDS; k++) begin
        r = $urandom_range(99, 0);
        case (mode)
          GEN_FILL:  grow = (r < 75);
          GEN_DRAIN: grow = (r < 25);
          default:   grow = (r < 50);
        endcase
        r = $urandom_range(99, 0);
        if (r < 14) f = FN_FIND;
        else if (r < 26) f = FN_MODIFY;
        else if (grow) begin
          case ($urandom_range(2, 0))
            0:       f = FN_INSERT;
            1:       f = FN_PUSH_BACK;
            default: f = FN_PUSH_FRONT;
          endcase
        end else begin
          case ($urandom_range(2, 0))
            0:       f = FN_ERASE;
            1:       f = FN_POP_BACK;
            default: f = FN_POP_FRONT;
          endcase
        end
        if ($urandom_range(9, 0) == 0) pos = $urandom_range(DEPTH, 0);
        else if (f == FN_INSERT) pos = $urandom_range(gen_len, 0);
        else if ((f == FN_ERASE || f == FN_MODIFY) && gen_len > 0)
          pos = $urandom_range(gen_len - 1, 0);
        else pos = $urandom_range(DEPTH, 0);
        if ($urandom_range(9, 0) < 7) v = val_pool[$urandom_range(15, 0)];
        else v = $urandom;
        add_cmd(f, pos, v);
        n++;
      end
    end
    cmd_total = cmd_q.size();

    repeat (12) @(negedge clk);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && rsp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd36_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
